@@ sv/ntp_header_parser_unit_macros.svh @@
// Assertion shorthands for the NTP header parser checker.
// Each macro expects clk and rst_n to be visible where it is used.
`ifndef NTP_HEADER_PARSER_UNIT_MACROS_SVH
`define NTP_HEADER_PARSER_UNIT_MACROS_SVH

// Same-cycle implication, disabled while reset is held.
`define NTP_CHK_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled while reset is held.
`define NTP_CHK_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

@@ sv/ntp_hp_pkg.sv @@
`default_nettype none

package ntp_hp_pkg;

  // Header geometry: the store is organised as 64-bit words of eight byte lanes.
  localparam int HEADER_BYTES   = 48;
  localparam int CNT_W          = $clog2(HEADER_BYTES + 1);
  localparam int LANES          = 8;
  localparam int LANE_W         = $clog2(LANES);
  localparam int WORDS_PER_BANK = HEADER_BYTES / LANES;
  localparam int WORD_W         = $clog2(WORDS_PER_BANK);
  localparam int BANKS          = 2;
  localparam int ADDR_W         = $clog2(BANKS) + WORD_W;
  localparam int MEM_DEPTH      = 2 ** ADDR_W;
  localparam int DATA_W         = 8 * LANES;

  // Job queue and result queue sizes.
  localparam int JOBQ_DEPTH = 2;
  localparam int JOBQ_CNT_W = 2;
  localparam int RESQ_DEPTH = 2;
  localparam int RESQ_CNT_W = 2;

  localparam logic [15:0] SERVICE_PORT_RST = 16'd123;
  localparam logic [2:0]  HDR_VERSION      = 3'd4;
  localparam logic [2:0]  MODE_CLIENT      = 3'd3;
  localparam logic [2:0]  MODE_SERVER      = 3'd4;
  localparam logic [7:0]  STRATUM_MAX      = 8'd16;
  localparam logic [7:0]  POLL_MAX         = 8'd17;

  // Kiss-o'-death reference identifiers, ASCII big-endian.
  localparam logic [31:0] KISS_WORD_INIT = 32'h494E_4954;
  localparam logic [31:0] KISS_WORD_STEP = 32'h5354_4550;
  localparam logic [31:0] KISS_WORD_DENY = 32'h4445_4E59;
  localparam logic [31:0] KISS_WORD_RATE = 32'h5241_5445;

  typedef enum logic [2:0] {
    ST_OK      = 3'd0,
    ST_PORT    = 3'd1,
    ST_SHORT   = 3'd2,
    ST_VERSION = 3'd3,
    ST_MODE    = 3'd4,
    ST_STRATUM = 3'd5,
    ST_POLL    = 3'd6
  } status_t;

  typedef enum logic [3:0] {
    FLD_LEAP       = 4'd0,
    FLD_VERSION    = 4'd1,
    FLD_MODE       = 4'd2,
    FLD_STRATUM    = 4'd3,
    FLD_POLL       = 4'd4,
    FLD_PRECISION  = 4'd5,
    FLD_DELAY      = 4'd6,
    FLD_DISPERSION = 4'd7,
    FLD_REFID      = 4'd8,
    FLD_KISS       = 4'd9,
    FLD_REF_TS     = 4'd10,
    FLD_ORG_TS     = 4'd11,
    FLD_RCV_TS     = 4'd12,
    FLD_XMT_TS     = 4'd13
  } field_t;

  typedef enum logic [2:0] {
    KISS_NONE = 3'd0,
    KISS_INIT = 3'd1,
    KISS_STEP = 3'd2,
    KISS_DENY = 3'd3,
    KISS_RATE = 3'd4
  } kiss_t;

  // One finished packet waiting for its results to be emitted.
  typedef struct packed {
    status_t status;
    logic    bank;
    logic    stratum_zero;
  } job_t;

  // Emitter feedback to the ingest side.
  typedef struct packed {
    logic pop;
    logic free_bank;
    logic bank;
  } job_ack_t;

  // One byte-lane write into the header store.
  typedef struct packed {
    logic              en;
    logic [ADDR_W-1:0] addr;
    logic [LANE_W-1:0] lane;
    logic [7:0]        data;
  } mem_wr_t;

  typedef struct packed {
    status_t     status;
    logic [3:0]  field_id;
    logic [63:0] field_value;
    logic        final_result;
  } result_t;

  // Store word that holds a given header field.
  function automatic logic [WORD_W-1:0] field_word(field_t fld);
    logic [WORD_W-1:0] w;
    w = '0;
    unique case (fld) inside
      FLD_LEAP, FLD_VERSION, FLD_MODE, FLD_STRATUM, FLD_POLL, FLD_PRECISION,
      FLD_DELAY:                          w = WORD_W'(0);
      FLD_DISPERSION, FLD_REFID, FLD_KISS: w = WORD_W'(1);
      FLD_REF_TS:                         w = WORD_W'(2);
      FLD_ORG_TS:                         w = WORD_W'(3);
      FLD_RCV_TS:                         w = WORD_W'(4);
      FLD_XMT_TS:                         w = WORD_W'(5);
      default:                            w = '0;
    endcase
    return w;
  endfunction

endpackage

`default_nettype wire

@@ sv/ntp_hp_byte_if.sv @@
`default_nettype none

interface ntp_hp_byte_if;
  logic        valid;
  logic        ready;
  logic [7:0]  data_byte;
  logic        first_byte;
  logic        last_byte;
  logic [15:0] source_port;
  logic [15:0] destination_port;

  modport source (
    output valid, data_byte, first_byte, last_byte, source_port, destination_port,
    input  ready
  );
  modport sink (
    input  valid, data_byte, first_byte, last_byte, source_port, destination_port,
    output ready
  );
endinterface

`default_nettype wire

@@ sv/ntp_hp_result_if.sv @@
`default_nettype none

interface ntp_hp_result_if;
  logic        valid;
  logic        ready;
  logic [2:0]  status;
  logic [3:0]  field_id;
  logic [63:0] field_value;
  logic        final_result;

  modport source (
    output valid, status, field_id, field_value, final_result,
    input  ready
  );
  modport sink (
    input  valid, status, field_id, field_value, final_result,
    output ready
  );
endinterface

`default_nettype wire

@@ sv/ntp_hp_store.sv @@
`default_nettype none

// Two-bank header store: byte-lane writes, one registered 64-bit word read.
module ntp_hp_store (
  input  wire logic                           clk,
  input  wire ntp_hp_pkg::mem_wr_t            wr,
  input  wire logic                           rd_en,
  input  wire logic [ntp_hp_pkg::ADDR_W-1:0]  rd_addr,
  output logic      [ntp_hp_pkg::DATA_W-1:0]  rd_data_r
);

  logic [ntp_hp_pkg::DATA_W-1:0] hdr_mem_r [ntp_hp_pkg::MEM_DEPTH];
  logic [ntp_hp_pkg::LANE_W+2:0] bit_base;

  // Lane zero is the most significant byte, so a word reads big-endian.
  always_comb begin
    bit_base = {ntp_hp_pkg::LANE_W'(ntp_hp_pkg::LANES - 1) - wr.lane, 3'b000};
  end

  always_ff @(posedge clk) begin
    if (wr.en) begin
      hdr_mem_r[wr.addr][bit_base +: 8] <= wr.data;
    end
    if (rd_en) begin
      rd_data_r <= hdr_mem_r[rd_addr];
    end
  end

endmodule

`default_nettype wire

@@ sv/ntp_hp_ingest.sv @@
`default_nettype none

// Byte intake: counts and stores header bytes, runs the header checks on the
// last byte and queues one job per packet.
module ntp_hp_ingest (
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  ntp_hp_byte_if.sink                in_ch,
  input  wire logic                  cfg_wr_en,
  input  wire logic [15:0]           cfg_wr_data,
  output ntp_hp_pkg::mem_wr_t        mem_wr,
  output ntp_hp_pkg::job_t           job_head,
  output logic                       job_vld,
  input  wire ntp_hp_pkg::job_ack_t  job_ack
);

  localparam int CW = ntp_hp_pkg::CNT_W;
  localparam int QW = ntp_hp_pkg::JOBQ_CNT_W;
  localparam logic [CW-1:0] HDR_CNT = CW'(ntp_hp_pkg::HEADER_BYTES);

  logic [CW-1:0] byte_cnt_r, byte_cnt_nxt;
  logic          pm_r, pm_nxt;
  logic [15:0]   svc_port_r;
  logic [7:0]    hdr0_r, stratum_r, poll_r;
  logic          wb_r, wb_nxt;
  logic [1:0]    busy_r, busy_nxt;

  ntp_hp_pkg::job_t q_mem_r [ntp_hp_pkg::JOBQ_DEPTH];
  logic             q_wp_r, q_rp_r;
  logic [QW-1:0]    q_cnt_r, q_cnt_nxt;

  logic                accept, push, good, store_en;
  logic [CW-1:0]       cnt_eff, cnt_end;
  logic                pm_eff;
  logic [7:0]          b0_eff, stratum_eff, poll_eff;
  ntp_hp_pkg::status_t status;
  ntp_hp_pkg::job_t    job_new;

  assign in_ch.ready = !busy_r[wb_r] && (q_cnt_r != QW'(ntp_hp_pkg::JOBQ_DEPTH));
  assign accept      = in_ch.valid && in_ch.ready;

  always_comb begin
    cnt_eff     = in_ch.first_byte ? '0 : byte_cnt_r;
    store_en    = cnt_eff < HDR_CNT;
    cnt_end     = store_en ? cnt_eff + CW'(1) : cnt_eff;
    pm_eff      = in_ch.first_byte ?
                  ((in_ch.source_port == svc_port_r) ||
                   (in_ch.destination_port == svc_port_r)) : pm_r;
    b0_eff      = (cnt_eff == CW'(0)) ? in_ch.data_byte : hdr0_r;
    stratum_eff = (cnt_eff == CW'(1)) ? in_ch.data_byte : stratum_r;
    poll_eff    = (cnt_eff == CW'(2)) ? in_ch.data_byte : poll_r;

    if (!pm_eff) begin
      status = ntp_hp_pkg::ST_PORT;
    end else if (cnt_end < HDR_CNT) begin
      status = ntp_hp_pkg::ST_SHORT;
    end else if (b0_eff[5:3] != ntp_hp_pkg::HDR_VERSION) begin
      status = ntp_hp_pkg::ST_VERSION;
    end else if ((b0_eff[2:0] != ntp_hp_pkg::MODE_CLIENT) &&
                 (b0_eff[2:0] != ntp_hp_pkg::MODE_SERVER)) begin
      status = ntp_hp_pkg::ST_MODE;
    end else if (stratum_eff > ntp_hp_pkg::STRATUM_MAX) begin
      status = ntp_hp_pkg::ST_STRATUM;
    end else if (poll_eff > ntp_hp_pkg::POLL_MAX) begin
      status = ntp_hp_pkg::ST_POLL;
    end else begin
      status = ntp_hp_pkg::ST_OK;
    end

    push = accept && in_ch.last_byte;
    good = push && (status == ntp_hp_pkg::ST_OK);

    job_new.status       = status;
    job_new.bank         = wb_r;
    job_new.stratum_zero = (stratum_eff == 8'd0);

    mem_wr.en   = accept && store_en;
    mem_wr.addr = {wb_r, cnt_eff[CW-1:ntp_hp_pkg::LANE_W]};
    mem_wr.lane = cnt_eff[ntp_hp_pkg::LANE_W-1:0];
    mem_wr.data = in_ch.data_byte;

    byte_cnt_nxt = byte_cnt_r;
    pm_nxt       = pm_r;
    if (accept) begin
      byte_cnt_nxt = in_ch.last_byte ? '0 : cnt_end;
      pm_nxt       = in_ch.last_byte ? 1'b0 : pm_eff;
    end

    // A good packet keeps its bank until its last field has been read.
    busy_nxt = busy_r;
    if (job_ack.free_bank) begin
      busy_nxt[job_ack.bank] = 1'b0;
    end
    if (good) begin
      busy_nxt[wb_r] = 1'b1;
    end
    wb_nxt = good ? !wb_r : wb_r;

    q_cnt_nxt = q_cnt_r + QW'(push) - QW'(job_ack.pop);
  end

  assign job_vld  = (q_cnt_r != '0);
  assign job_head = q_mem_r[q_rp_r];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      byte_cnt_r <= '0;
      pm_r       <= 1'b0;
      svc_port_r <= ntp_hp_pkg::SERVICE_PORT_RST;
      wb_r       <= 1'b0;
      busy_r     <= '0;
      q_wp_r     <= 1'b0;
      q_rp_r     <= 1'b0;
      q_cnt_r    <= '0;
    end else begin
      byte_cnt_r <= byte_cnt_nxt;
      pm_r       <= pm_nxt;
      wb_r       <= wb_nxt;
      busy_r     <= busy_nxt;
      q_cnt_r    <= q_cnt_nxt;
      if (cfg_wr_en) begin
        svc_port_r <= cfg_wr_data;
      end
      if (push) begin
        q_wp_r <= !q_wp_r;
      end
      if (job_ack.pop) begin
        q_rp_r <= !q_rp_r;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      q_mem_r[q_wp_r] <= job_new;
    end
    if (accept && (cnt_eff == CW'(0))) begin
      hdr0_r <= in_ch.data_byte;
    end
    if (accept && (cnt_eff == CW'(1))) begin
      stratum_r <= in_ch.data_byte;
    end
    if (accept && (cnt_eff == CW'(2))) begin
      poll_r <= in_ch.data_byte;
    end
  end

endmodule

`default_nettype wire

@@ sv/ntp_hp_emit.sv @@
`default_nettype none

// Result sequencer: walks the fields of the head job, reads one store word per
// good-job field, formats it and queues the result for the output channel.
module ntp_hp_emit (
  input  wire logic                           clk,
  input  wire logic                           rst_n,
  input  wire ntp_hp_pkg::job_t               job_head,
  input  wire logic                           job_vld,
  output ntp_hp_pkg::job_ack_t                job_ack,
  output logic                                rd_en,
  output logic      [ntp_hp_pkg::ADDR_W-1:0]  rd_addr,
  input  wire logic [ntp_hp_pkg::DATA_W-1:0]  rd_data,
  ntp_hp_result_if.source                     out_ch
);

  localparam int RW = ntp_hp_pkg::RESQ_CNT_W;

  ntp_hp_pkg::field_t  fid_r, fid_nxt;
  logic                s1_vld_r;
  ntp_hp_pkg::status_t s1_status_r;
  ntp_hp_pkg::field_t  s1_fid_r;
  logic                s1_kz_r;
  logic                s1_final_r;

  ntp_hp_pkg::result_t rq_mem_r [ntp_hp_pkg::RESQ_DEPTH];
  logic                rq_wp_r, rq_rp_r;
  logic [RW-1:0]       rq_cnt_r;

  logic                is_err, last_fld, issue, pop_out;
  logic [RW:0]         occupancy;
  logic [31:0]         refid;
  ntp_hp_pkg::kiss_t   kiss;
  ntp_hp_pkg::result_t res;

  always_comb begin
    pop_out   = out_ch.valid && out_ch.ready;
    // Queue occupancy after this cycle, counting the read already in flight.
    occupancy = (RW+1)'(rq_cnt_r) + (RW+1)'(s1_vld_r) - (RW+1)'(pop_out);
    is_err    = (job_head.status != ntp_hp_pkg::ST_OK);
    last_fld  = is_err || (fid_r == ntp_hp_pkg::FLD_XMT_TS);
    issue     = job_vld && (occupancy < (RW+1)'(ntp_hp_pkg::RESQ_DEPTH));

    job_ack.pop       = issue && last_fld;
    job_ack.free_bank = issue && !is_err && (fid_r == ntp_hp_pkg::FLD_XMT_TS);
    job_ack.bank      = job_head.bank;

    rd_en   = issue && !is_err;
    rd_addr = {job_head.bank, ntp_hp_pkg::field_word(fid_r)};

    fid_nxt = fid_r;
    if (issue) begin
      fid_nxt = last_fld ? ntp_hp_pkg::FLD_LEAP : ntp_hp_pkg::field_t'(fid_r + 4'd1);
    end
  end

  // Field extraction from the registered store word.
  always_comb begin
    refid = rd_data[31:0];
    kiss  = ntp_hp_pkg::KISS_NONE;
    if (s1_kz_r) begin
      if (refid == ntp_hp_pkg::KISS_WORD_INIT) begin
        kiss = ntp_hp_pkg::KISS_INIT;
      end else if (refid == ntp_hp_pkg::KISS_WORD_STEP) begin
        kiss = ntp_hp_pkg::KISS_STEP;
      end else if (refid == ntp_hp_pkg::KISS_WORD_DENY) begin
        kiss = ntp_hp_pkg::KISS_DENY;
      end else if (refid == ntp_hp_pkg::KISS_WORD_RATE) begin
        kiss = ntp_hp_pkg::KISS_RATE;
      end
    end

    res.status       = s1_status_r;
    res.field_id     = s1_fid_r;
    res.final_result = s1_final_r;
    res.field_value  = '0;
    if (s1_status_r == ntp_hp_pkg::ST_OK) begin
      unique case (s1_fid_r)
        ntp_hp_pkg::FLD_LEAP:       res.field_value = 64'(rd_data[63:62]);
        ntp_hp_pkg::FLD_VERSION:    res.field_value = 64'(rd_data[61:59]);
        ntp_hp_pkg::FLD_MODE:       res.field_value = 64'(rd_data[58:56]);
        ntp_hp_pkg::FLD_STRATUM:    res.field_value = 64'(rd_data[55:48]);
        ntp_hp_pkg::FLD_POLL:       res.field_value = 64'(rd_data[47:40]);
        ntp_hp_pkg::FLD_PRECISION:  res.field_value = 64'(rd_data[39:32]);
        ntp_hp_pkg::FLD_DELAY:      res.field_value = 64'(rd_data[31:0]);
        ntp_hp_pkg::FLD_DISPERSION: res.field_value = 64'(rd_data[63:32]);
        ntp_hp_pkg::FLD_REFID:      res.field_value = 64'(refid);
        ntp_hp_pkg::FLD_KISS:       res.field_value = 64'(kiss);
        ntp_hp_pkg::FLD_REF_TS,
        ntp_hp_pkg::FLD_ORG_TS,
        ntp_hp_pkg::FLD_RCV_TS,
        ntp_hp_pkg::FLD_XMT_TS:     res.field_value = rd_data;
        default:                    res.field_value = '0;
      endcase
    end
  end

  assign out_ch.valid        = (rq_cnt_r != '0);
  assign out_ch.status       = rq_mem_r[rq_rp_r].status;
  assign out_ch.field_id     = rq_mem_r[rq_rp_r].field_id;
  assign out_ch.field_value  = rq_mem_r[rq_rp_r].field_value;
  assign out_ch.final_result = rq_mem_r[rq_rp_r].final_result;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fid_r    <= ntp_hp_pkg::FLD_LEAP;
      s1_vld_r <= 1'b0;
      rq_wp_r  <= 1'b0;
      rq_rp_r  <= 1'b0;
      rq_cnt_r <= '0;
    end else begin
      fid_r    <= fid_nxt;
      s1_vld_r <= issue;
      rq_cnt_r <= rq_cnt_r + RW'(s1_vld_r) - RW'(pop_out);
      if (s1_vld_r) begin
        rq_wp_r <= !rq_wp_r;
      end
      if (pop_out) begin
        rq_rp_r <= !rq_rp_r;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (issue) begin
      s1_status_r <= job_head.status;
      s1_fid_r    <= is_err ? ntp_hp_pkg::FLD_LEAP : fid_r;
      s1_kz_r     <= job_head.stratum_zero;
      s1_final_r  <= last_fld;
    end
    if (s1_vld_r) begin
      rq_mem_r[rq_wp_r] <= res;
    end
  end

endmodule

`default_nettype wire

@@ sv/ntp_header_parser_unit.sv @@
// Channel   Direction  Transfer payload
// in_ch     sink       data_byte, first_byte, last_byte, source_port, destination_port
// out_ch    source     status, field_id, field_value, final_result
// cfg_*     write      cfg_wr_data = service_port, taken when cfg_wr_en is high
//
// One payload byte is taken per cycle while in_ch is ready. A packet that
// passes its checks gives 14 results, one per cycle while out_ch is ready;
// a failed packet gives one result. The intake, from state the emitter
// frees, sets when input stalls: in_ch waits while two packets sit in the
// job queue, or while the bank it would write still holds unread fields.
// Reset is synchronous and active low; the store needs no clearing pass.
`default_nettype none

module ntp_header_parser_unit (
  input  wire logic        clk,
  input  wire logic        rst_n,
  ntp_hp_byte_if.sink      in_ch,
  ntp_hp_result_if.source  out_ch,
  input  wire logic        cfg_wr_en,
  input  wire logic [15:0] cfg_wr_data
);

  // The header store holds two banks of 48 bytes, laid out as six 64-bit words
  // each. While the results of one good packet are read from one bank, the
  // next packet is written into the other, so a stream of back-to-back
  // packets loads and drains at the same time.
  ntp_hp_pkg::mem_wr_t                mem_wr;
  ntp_hp_pkg::job_t                   job_head;
  logic                               job_vld;
  ntp_hp_pkg::job_ack_t               job_ack;
  logic                               rd_en;
  logic [ntp_hp_pkg::ADDR_W-1:0]      rd_addr;
  logic [ntp_hp_pkg::DATA_W-1:0]      rd_data;

  // Intake side: byte counting, port match, checks on the last byte, bank
  // selection and the queue of finished packets.
  ntp_hp_ingest u_ingest (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_ch       (in_ch),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data),
    .mem_wr      (mem_wr),
    .job_head    (job_head),
    .job_vld     (job_vld),
    .job_ack     (job_ack)
  );

  // Dual-bank store with byte-lane writes and a registered word read.
  ntp_hp_store u_store (
    .clk       (clk),
    .wr        (mem_wr),
    .rd_en     (rd_en),
    .rd_addr   (rd_addr),
    .rd_data_r (rd_data)
  );

  // Emitter: one store read per field of a good packet, then a two-entry result
  // queue that decouples the output transfer from the read pipeline.
  ntp_hp_emit u_emit (
    .clk      (clk),
    .rst_n    (rst_n),
    .job_head (job_head),
    .job_vld  (job_vld),
    .job_ack  (job_ack),
    .rd_en    (rd_en),
    .rd_addr  (rd_addr),
    .rd_data  (rd_data),
    .out_ch   (out_ch)
  );

endmodule

`default_nettype wire

@@ sv/ntp_header_parser_unit_checker.sv @@
`default_nettype none
`include "ntp_header_parser_unit_macros.svh"

module ntp_header_parser_unit_checker (
  input wire logic        clk,
  input wire logic        rst_n,
  input wire logic        out_valid,
  input wire logic        out_ready,
  input wire logic [2:0]  out_status,
  input wire logic [3:0]  out_field_id,
  input wire logic [63:0] out_field_value,
  input wire logic        out_final_result
);

  `NTP_CHK_NXT(a_out_hold, out_valid && !out_ready,
    out_valid && $stable(out_field_id) && $stable(out_field_value),
    "stalled result transfer changed")

  `NTP_CHK_IMP(a_err_shape, out_valid && (out_status != ntp_hp_pkg::ST_OK),
    out_final_result && (out_field_id == 4'(ntp_hp_pkg::FLD_LEAP)) && (out_field_value == '0),
    "error result is not a single empty final result")

  `NTP_CHK_IMP(a_final_xmt, out_valid && (out_status == ntp_hp_pkg::ST_OK),
    out_final_result == (out_field_id == 4'(ntp_hp_pkg::FLD_XMT_TS)),
    "final flag does not match the transmit timestamp field")

  `NTP_CHK_IMP(a_version, out_valid && (out_status == ntp_hp_pkg::ST_OK) &&
    (out_field_id == 4'(ntp_hp_pkg::FLD_VERSION)),
    out_field_value == 64'(ntp_hp_pkg::HDR_VERSION),
    "accepted packet reports a version other than four")

  `NTP_CHK_IMP(a_kiss_range, out_valid && (out_status == ntp_hp_pkg::ST_OK) &&
    (out_field_id == 4'(ntp_hp_pkg::FLD_KISS)),
    out_field_value <= 64'(ntp_hp_pkg::KISS_RATE),
    "kiss code out of range")

endmodule

bind ntp_header_parser_unit ntp_header_parser_unit_checker u_checker (
  .clk              (clk),
  .rst_n            (rst_n),
  .out_valid        (out_ch.valid),
  .out_ready        (out_ch.ready),
  .out_status       (out_ch.status),
  .out_field_id     (out_ch.field_id),
  .out_field_value  (out_ch.field_value),
  .out_final_result (out_ch.final_result)
);

`default_nettype wire
